[sv/gdnc_pkg.sv]
// Shared definitions of the Gregorian day number converter: field widths,
// operation codes, cycle lengths and the cumulative month table.
// No dependencies.
package gdnc_pkg;

   localparam int MAX_YEAR_DEFAULT = 9999;

   localparam int FUNC_W   = 2;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int SERIAL_W = 22;
   localparam int OFFSET_W = 23;

   // Internal serial width: a date plus an offset stays below 2**24.
   localparam int SER_W  = 24;
   // Date serial of any 14-bit year fits in 23 bits.
   localparam int DS_W   = 23;
   // Signed sum of date serial and offset, and room for the last serial.
   localparam int SUM_W  = 26;

   localparam logic [FUNC_W-1:0] FUNC_TO_SERIAL = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TO_DATE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD       = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIFF      = 2'd3;

   localparam int DAYS_400 = 146097;
   localparam int DAYS_100 = 36524;
   localparam int DAYS_4   = 1461;
   localparam int DAYS_1   = 365;

   // Date serial and the fields that travel with it to the range check.
   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [SERIAL_W-1:0] in_serial;
      logic [OFFSET_W-1:0] offset;
      logic [DS_W-1:0]     ds;
   } ds_type;

   // What follows an item down the calendar split.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              err;
      logic [SER_W-1:0]  s;
   } tag_type;

   // Days of the year before month idx+1 (idx 0 is January).
   function automatic logic [8:0] cum_days(input logic [3:0] idx, input logic leap);
      logic [8:0] v;
      case (idx)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd59;
         4'd3:    v = 9'd90;
         4'd4:    v = 9'd120;
         4'd5:    v = 9'd151;
         4'd6:    v = 9'd181;
         4'd7:    v = 9'd212;
         4'd8:    v = 9'd243;
         4'd9:    v = 9'd273;
         4'd10:   v = 9'd304;
         4'd11:   v = 9'd334;
         default: v = 9'd365;
      endcase
      if (leap && idx >= 4'd2) begin
         v = v + 9'd1;
      end
      return v;
   endfunction

endpackage

[sv/gdnc_if.sv]
// Handshake channels of the converter: request and response items.
// Depends on gdnc_pkg for the field widths.
interface gdnc_req_if import gdnc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [DAY_W-1:0]    in_day;
   logic [MONTH_W-1:0]  in_month;
   logic [YEAR_W-1:0]   in_year;
   logic [SERIAL_W-1:0] in_serial;
   logic [OFFSET_W-1:0] offset;

   modport source (output valid, func, in_day, in_month, in_year, in_serial, offset,
                   input ready);
   modport sink (input valid, func, in_day, in_month, in_year, in_serial, offset,
                 output ready);
endinterface

interface gdnc_rsp_if import gdnc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DAY_W-1:0]    out_day;
   logic [MONTH_W-1:0]  out_month;
   logic [YEAR_W-1:0]   out_year;
   logic [SERIAL_W-1:0] out_serial;
   logic                range_error;

   modport source (output valid, out_day, out_month, out_year, out_serial, range_error,
                   input ready);
   modport sink (input valid, out_day, out_month, out_year, out_serial, range_error,
                 output ready);
endinterface

[sv/gdnc_date_serial.sv]
// Two-stage date to serial day number: year clamp and reciprocal products,
// then leap year rule and the serial sum. Depends on gdnc_pkg.
module gdnc_date_serial import gdnc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_v,
   input  logic [FUNC_W-1:0]   func,
   input  logic [DAY_W-1:0]    in_day,
   input  logic [MONTH_W-1:0]  in_month,
   input  logic [YEAR_W-1:0]   in_year,
   input  logic [SERIAL_W-1:0] in_serial,
   input  logic [OFFSET_W-1:0] offset,
   output logic                out_v,
   output ds_type              out_ds
);
   // floor(n/100) = (n*5243) >> 19 for every 14-bit n.
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int          PROD_W    = YEAR_W + 13;

   logic                a_v_ff;
   logic [YEAR_W-1:0]   a_yy_ff, a_y1_ff;
   logic [PROD_W-1:0]   a_py_ff, a_p1_ff;
   logic [MONTH_W-1:0]  a_mm_ff;
   logic [DAY_W-1:0]    a_day_ff;
   logic [FUNC_W-1:0]   a_func_ff;
   logic [SERIAL_W-1:0] a_sin_ff;
   logic [OFFSET_W-1:0] a_off_ff;

   logic [YEAR_W-1:0]  yy_in, y1_in;
   logic [MONTH_W-1:0] mm_in;

   logic          b_v_ff;
   ds_type        b_ds_ff;
   logic [7:0]    qy, q1;
   logic          leap;
   logic [DS_W-1:0] ds_in;

   always_comb begin
      yy_in = (in_year == '0) ? YEAR_W'(1) : in_year;
      y1_in = yy_in - YEAR_W'(1);
      if (in_month == '0) begin
         mm_in = MONTH_W'(1);
      end else if (in_month > MONTH_W'(12)) begin
         mm_in = MONTH_W'(12);
      end else begin
         mm_in = in_month;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_v;
         b_v_ff <= a_v_ff;
      end
      if (en) begin
         a_yy_ff   <= yy_in;
         a_y1_ff   <= y1_in;
         a_py_ff   <= PROD_W'(yy_in) * PROD_W'(RECIP_100);
         a_p1_ff   <= PROD_W'(y1_in) * PROD_W'(RECIP_100);
         a_mm_ff   <= mm_in;
         a_day_ff  <= in_day;
         a_func_ff <= func;
         a_sin_ff  <= in_serial;
         a_off_ff  <= offset;
         b_ds_ff.func      <= a_func_ff;
         b_ds_ff.in_serial <= a_sin_ff;
         b_ds_ff.offset    <= a_off_ff;
         b_ds_ff.ds        <= ds_in;
      end
   end

   always_comb begin
      qy   = a_py_ff[19 +: 8];
      q1   = a_p1_ff[19 +: 8];
      leap = (a_yy_ff[1:0] == 2'b00)
             && ((a_yy_ff != YEAR_W'(qy) * YEAR_W'(100)) || (qy[1:0] == 2'b00));
      ds_in = DS_W'(a_y1_ff) * DS_W'(365) + DS_W'(a_y1_ff >> 2) - DS_W'(q1)
              + DS_W'(q1 >> 2) + DS_W'(cum_days(a_mm_ff - MONTH_W'(1), leap))
              + DS_W'(a_day_ff);
   end

   assign out_v  = b_v_ff;
   assign out_ds = b_ds_ff;

endmodule

[sv/gdnc_div_const.sv]
// Three-stage division by a constant: reciprocal product, trial remainder,
// one correction step. No dependencies.
module gdnc_div_const #(
   parameter int W  = 24,
   parameter int D  = 146097,
   parameter int QW = 7,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_v,
   input  logic [W-1:0]  in_r,
   input  logic [SW-1:0] in_side,
   output logic          out_v,
   output logic [QW-1:0] out_q,
   output logic [W-1:0]  out_rem,
   output logic [SW-1:0] out_side
);
   // floor(2**W / D): the estimate is the true quotient or one less.
   localparam logic [63:0]  MUL64 = (64'd1 << W) / D;
   localparam logic [W-1:0] MUL   = MUL64[W-1:0];
   localparam logic [W-1:0] DC    = W'(D);

   logic            v1_ff, v2_ff, v3_ff;
   logic [2*W-1:0]  prod1_ff;
   logic [W-1:0]    r1_ff, rem2_ff, rem3_ff;
   logic [QW-1:0]   q2_ff, q3_ff;
   logic [SW-1:0]   side1_ff, side2_ff, side3_ff;
   logic [QW-1:0]   qe_in;
   logic [W-1:0]    rem2_in;

   always_comb begin
      qe_in   = prod1_ff[W +: QW];
      rem2_in = r1_ff - W'(W'(qe_in) * DC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_v;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         prod1_ff <= {{W{1'b0}}, in_r} * {{W{1'b0}}, MUL};
         r1_ff    <= in_r;
         side1_ff <= in_side;
         q2_ff    <= qe_in;
         rem2_ff  <= rem2_in;
         side2_ff <= side1_ff;
         if (rem2_ff >= DC) begin
            q3_ff   <= q2_ff + QW'(1);
            rem3_ff <= rem2_ff - DC;
         end else begin
            q3_ff   <= q2_ff;
            rem3_ff <= rem2_ff;
         end
         side3_ff <= side2_ff;
      end
   end

   assign out_v    = v3_ff;
   assign out_q    = q3_ff;
   assign out_rem  = rem3_ff;
   assign out_side = side3_ff;

endmodule

[sv/gdnc_serial_date.sv]
// Serial day number to date: splits into 400, 100, 4 and 1 year cycles,
// then finds month and day; also forms the registered result item.
// Depends on gdnc_pkg and gdnc_div_const.
module gdnc_serial_date import gdnc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_v,
   input  logic [SER_W-1:0]    in_r,
   input  tag_type             in_tag,
   output logic                out_v,
   output logic [DAY_W-1:0]    out_day,
   output logic [MONTH_W-1:0]  out_month,
   output logic [YEAR_W-1:0]   out_year,
   output logic [SERIAL_W-1:0] out_serial,
   output logic                out_err
);
   localparam int TW  = $bits(tag_type);
   localparam int R1W = 18;
   localparam int R2W = 17;
   localparam int R3W = 11;
   localparam int R4W = 9;
   localparam int Q1W = 7;
   localparam int Q2W = 3;
   localparam int Q3W = 6;
   localparam int Q4W = 3;

   logic                v1, v2, v3, v4;
   logic [Q1W-1:0]      n400, n400_b, n400_c;
   logic [Q2W-1:0]      q100;
   logic [1:0]          n100, n100_c;
   logic [Q3W-1:0]      n4;
   logic [Q4W-1:0]      q1;
   logic [1:0]          n1;
   logic [SER_W-1:0]    rem1_w;
   logic [R1W-1:0]      rem1;
   logic [R1W-1:0]      rem2;
   logic [R2W-1:0]      r2;
   logic [R2W-1:0]      rem3;
   logic [R3W-1:0]      rem4;
   logic [R4W-1:0]      r4;
   tag_type             t1, t2, t3, t4;

   gdnc_div_const #(.W(SER_W), .D(DAYS_400), .QW(Q1W), .SW(TW)) u_div400 (
      .clock(clock), .reset(reset), .en(en), .in_v(in_v), .in_r(in_r), .in_side(in_tag),
      .out_v(v1), .out_q(n400), .out_rem(rem1_w), .out_side(t1)
   );

   // What is left after the 400-year cycles is always below one cycle length.
   assign rem1 = rem1_w[R1W-1:0];

   gdnc_div_const #(.W(R1W), .D(DAYS_100), .QW(Q2W), .SW(TW + Q1W)) u_div100 (
      .clock(clock), .reset(reset), .en(en), .in_v(v1), .in_r(rem1),
      .in_side({n400, t1}),
      .out_v(v2), .out_q(q100), .out_rem(rem2), .out_side({n400_b, t2})
   );

   // The last day of a 400-year cycle would give a fifth century; keep it in the fourth.
   always_comb begin
      if (q100 > Q2W'(3)) begin
         n100 = 2'd3;
         r2   = R2W'(rem2 + R1W'(DAYS_100));
      end else begin
         n100 = q100[1:0];
         r2   = R2W'(rem2);
      end
   end

   gdnc_div_const #(.W(R2W), .D(DAYS_4), .QW(Q3W), .SW(TW + Q1W + 2)) u_div4 (
      .clock(clock), .reset(reset), .en(en), .in_v(v2), .in_r(r2),
      .in_side({n400_b, n100, t2}),
      .out_v(v3), .out_q(n4), .out_rem(rem3), .out_side({n400_c, n100_c, t3})
   );

   logic [Q1W-1:0] n400_d;
   logic [1:0]     n100_d;
   logic [Q3W-1:0] n4_d;

   gdnc_div_const #(.W(R3W), .D(DAYS_1), .QW(Q4W), .SW(TW + Q1W + 2 + Q3W)) u_div1 (
      .clock(clock), .reset(reset), .en(en), .in_v(v3), .in_r(R3W'(rem3)),
      .in_side({n400_c, n100_c, n4, t3}),
      .out_v(v4), .out_q(q1), .out_rem(rem4), .out_side({n400_d, n100_d, n4_d, t4})
   );

   // The last day of a four-year cycle belongs to its leap year.
   always_comb begin
      if (q1 > Q4W'(3)) begin
         n1 = 2'd3;
         r4 = R4W'(rem4 + R3W'(DAYS_1));
      end else begin
         n1 = q1[1:0];
         r4 = R4W'(rem4);
      end
   end

   logic            m_v_ff;
   logic [3:0]      m_month_ff;
   logic            m_leap_ff;
   logic [R4W-1:0]  m_r_ff;
   logic [15:0]     m_year_ff;
   tag_type         m_tag_ff;
   logic            leap_in;
   logic [3:0]      month_in;
   logic [15:0]     year_in;

   always_comb begin
      leap_in  = (n1 == 2'd3) && ((n4_d != Q3W'(24)) || (n100_d == 2'd3));
      month_in = 4'd1;
      for (int mo = 1; mo < 12; mo++) begin
         if (r4 >= cum_days(4'(mo), leap_in)) begin
            month_in = month_in + 4'd1;
         end
      end
      year_in = 16'(n400_d) * 16'd400 + 16'(n100_d) * 16'd100 + 16'(n4_d) * 16'd4
                + 16'(n1) + 16'd1;
   end

   logic                o_v_ff;
   logic [DAY_W-1:0]    o_day_ff;
   logic [MONTH_W-1:0]  o_month_ff;
   logic [YEAR_W-1:0]   o_year_ff;
   logic [SERIAL_W-1:0] o_serial_ff;
   logic                o_err_ff;
   logic [R4W-1:0]      day_in;
   logic                show_date;

   always_comb begin
      day_in    = m_r_ff - cum_days(m_month_ff - 4'd1, m_leap_ff) + R4W'(1);
      show_date = !m_tag_ff.err
                  && (m_tag_ff.func == FUNC_TO_DATE || m_tag_ff.func == FUNC_ADD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= v4;
         o_v_ff <= m_v_ff;
      end
      if (en) begin
         m_month_ff <= month_in;
         m_leap_ff  <= leap_in;
         m_r_ff     <= r4;
         m_year_ff  <= year_in;
         m_tag_ff   <= t4;
         o_day_ff    <= show_date ? DAY_W'(day_in) : '0;
         o_month_ff  <= show_date ? m_month_ff : '0;
         o_year_ff   <= show_date ? m_year_ff[YEAR_W-1:0] : '0;
         o_serial_ff <= m_tag_ff.err ? '0 : m_tag_ff.s[SERIAL_W-1:0];
         o_err_ff    <= m_tag_ff.err;
      end
   end

   assign out_v      = o_v_ff;
   assign out_day    = o_day_ff;
   assign out_month  = o_month_ff;
   assign out_year   = o_year_ff;
   assign out_serial = o_serial_ff;
   assign out_err    = o_err_ff;

endmodule

[sv/gregorian_day_number_converter.sv]
// Top level of the Gregorian day number converter; ties the stages together.
// Depends on gdnc_pkg, gdnc_if, gdnc_date_serial and gdnc_serial_date.

// Converts proleptic Gregorian dates to serial day numbers (1/1/1 is day 1)
// and back, adds a signed day offset to a date, or gives the distance between
// a date and a serial. It is a 17-stage pipeline: two stages for the date
// serial, one for the range check and operation select, twelve for the
// constant divisions by the 400, 100, 4 and 1 year cycle lengths and two for
// month and day. An item can enter every cycle while the pipeline is not halted;
// the whole pipeline halts while a finished result is held back.
module gregorian_day_number_converter import gdnc_pkg::*; #(
   parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   gdnc_req_if.sink  req_if,
   gdnc_rsp_if.source rsp_if
);
   localparam logic [SUM_W-1:0] LAST_SERIAL = SUM_W'(365 * MAX_YEAR + MAX_YEAR / 4
                                                     - MAX_YEAR / 100 + MAX_YEAR / 400);

   logic   en;
   logic   ds_v;
   ds_type ds;

   assign en           = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = en;

   gdnc_date_serial u_date_serial (
      .clock(clock), .reset(reset), .en(en), .in_v(req_if.valid),
      .func(req_if.func), .in_day(req_if.in_day), .in_month(req_if.in_month),
      .in_year(req_if.in_year), .in_serial(req_if.in_serial), .offset(req_if.offset),
      .out_v(ds_v), .out_ds(ds)
   );

   logic [SUM_W-1:0] sum, ds_w, sin_w, diff;
   logic             ok_sum, ok_ds, ok_sin;
   tag_type          tag_in;
   logic [SER_W-1:0] r_in;

   always_comb begin
      ds_w  = SUM_W'(ds.ds);
      sin_w = SUM_W'(ds.in_serial);
      sum   = ds_w + {{(SUM_W - OFFSET_W){ds.offset[OFFSET_W-1]}}, ds.offset};
      diff  = (ds_w > sin_w) ? ds_w - sin_w : sin_w - ds_w;
      // The sum is negative when its top bit is set.
      ok_sum = !sum[SUM_W-1] && (sum != '0) && (sum <= LAST_SERIAL);
      ok_ds  = (ds_w != '0) && (ds_w <= LAST_SERIAL);
      ok_sin = (sin_w != '0) && (sin_w <= LAST_SERIAL);
      tag_in.func = ds.func;
      case (ds.func)
         FUNC_TO_SERIAL: begin
            tag_in.err = !ok_ds;
            tag_in.s   = SER_W'(ds_w);
         end
         FUNC_TO_DATE: begin
            tag_in.err = !ok_sin;
            tag_in.s   = SER_W'(sin_w);
         end
         FUNC_ADD: begin
            tag_in.err = !ok_sum;
            tag_in.s   = SER_W'(sum);
         end
         default: begin
            tag_in.err = !(ok_ds && ok_sin);
            tag_in.s   = SER_W'(diff);
         end
      endcase
      r_in = tag_in.s - SER_W'(1);
   end

   logic             c_v_ff;
   tag_type          c_tag_ff;
   logic [SER_W-1:0] c_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= ds_v;
      end
      if (en) begin
         c_tag_ff <= tag_in;
         c_r_ff   <= r_in;
      end
   end

   gdnc_serial_date u_serial_date (
      .clock(clock), .reset(reset), .en(en), .in_v(c_v_ff), .in_r(c_r_ff),
      .in_tag(c_tag_ff),
      .out_v(rsp_if.valid), .out_day(rsp_if.out_day), .out_month(rsp_if.out_month),
      .out_year(rsp_if.out_year), .out_serial(rsp_if.out_serial),
      .out_err(rsp_if.range_error)
   );

endmodule

[test/gdnc_checker.sv]
// Checker of the Gregorian day number converter: watches both channels,
// predicts each response item from its request item and compares them.
// Depends on gdnc_pkg and gdnc_if.
module gdnc_checker import gdnc_pkg::*; #(
   parameter int MAX_YEAR = MAX_YEAR_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   gdnc_req_if.sink   req_mon,
   gdnc_rsp_if.sink   rsp_mon,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [SERIAL_W-1:0] serial;
      logic                err;
   } outcome_type;

   outcome_type expected_dates[$];

   function automatic logic leap_year(longint y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic longint leaps_upto(longint y);
      return y / 4 - y / 100 + y / 400;
   endfunction

   function automatic int month_start(int m, logic lp);
      int tbl[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      return tbl[m] + ((lp && m >= 2) ? 1 : 0);
   endfunction

   function automatic longint serial_of(int d, int m, int y);
      if (y < 1) y = 1;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      return 365 * longint'(y - 1) + leaps_upto(y - 1) + month_start(m - 1, leap_year(y)) + d;
   endfunction

   function automatic logic serial_valid(longint s);
      return s >= 1 && s <= 365 * longint'(MAX_YEAR) + leaps_upto(MAX_YEAR);
   endfunction

   function automatic outcome_type date_of(longint s);
      outcome_type o;
      longint r, q400, q100, q4, q1, y;
      int mo;
      o = '0;
      r = s - 1;
      q400 = r / DAYS_400;
      r = r % DAYS_400;
      q100 = r / DAYS_100;
      if (q100 > 3) q100 = 3;
      r -= q100 * DAYS_100;
      q4 = r / DAYS_4;
      r = r % DAYS_4;
      q1 = r / 365;
      if (q1 > 3) q1 = 3;
      r -= q1 * 365;
      y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
      mo = 1;
      while (mo < 12 && r >= month_start(mo, leap_year(y))) mo++;
      o.day = DAY_W'(r - month_start(mo - 1, leap_year(y)) + 1);
      o.month = MONTH_W'(mo);
      o.year = YEAR_W'(y);
      o.serial = SERIAL_W'(s);
      return o;
   endfunction

   function automatic outcome_type convert(logic [FUNC_W-1:0] fn, int d, int m, int y,
                                           longint sin, longint off);
      outcome_type o;
      longint ds, t;
      o = '0;
      ds = serial_of(d, m, y);
      case (fn)
         FUNC_TO_SERIAL: if (serial_valid(ds)) o.serial = SERIAL_W'(ds); else o.err = 1'b1;
         FUNC_TO_DATE:   if (serial_valid(sin)) o = date_of(sin); else o.err = 1'b1;
         FUNC_ADD: begin
            t = ds + off;
            if (serial_valid(t)) o = date_of(t); else o.err = 1'b1;
         end
         default: begin
            if (serial_valid(ds) && serial_valid(sin))
               o.serial = SERIAL_W'(ds > sin ? ds - sin : sin - ds);
            else
               o.err = 1'b1;
         end
      endcase
      return o;
   endfunction

   assign pending = expected_dates.size();

   always @(posedge clock) begin
      outcome_type want, got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_dates.push_back(convert(req_mon.func, req_mon.in_day, req_mon.in_month,
                                             req_mon.in_year, req_mon.in_serial,
                                             longint'($signed(req_mon.offset))));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.out_day, rsp_mon.out_month, rsp_mon.out_year,
                    rsp_mon.out_serial, rsp_mon.range_error};
            if (expected_dates.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("Unexpected response item %p", got);
            end else begin
               want = expected_dates.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("Mismatch: expected %p, got %p", want, got);
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

[test/tb_gregorian_day_number_converter.sv]
// Top of the converter testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on gdnc_pkg, gdnc_if and gdnc_checker.
module tb_gregorian_day_number_converter import gdnc_pkg::*;;

   localparam int LAST_SERIAL = 3652059;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending;
   logic calm, sender_done;

   gdnc_req_if req_ch();
   gdnc_rsp_if rsp_ch();

   gregorian_day_number_converter uut (.clock(clock), .reset(reset),
                                       .req_if(req_ch.sink), .rsp_if(rsp_ch.source));

   gdnc_checker watcher (.clock(clock), .reset(reset), .req_mon(req_ch.sink),
                         .rsp_mon(rsp_ch.sink), .fail_count(fail_count), .pending(pending));

   initial forever #5 clock = ~clock;

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic offer(logic [FUNC_W-1:0] fn, int d, int m, int y, int s, int off);
      req_ch.valid     <= 1'b1;
      req_ch.func      <= fn;
      req_ch.in_day    <= DAY_W'(d);
      req_ch.in_month  <= MONTH_W'(m);
      req_ch.in_year   <= YEAR_W'(y);
      req_ch.in_serial <= SERIAL_W'(s);
      req_ch.offset    <= OFFSET_W'(off);
      do @(posedge clock); while (!req_ch.ready);
      // Idle gaps only outside the calm stretch.
      if (!calm && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic random_date_item();
      logic [FUNC_W-1:0] fn;
      int y, s, off;
      fn = FUNC_W'($urandom_range(3));
      case ($urandom_range(5))
         0:       y = $urandom_range(16383);
         1:       y = $urandom_range(9990, 9999);
         2:       y = $urandom_range(1, 4);
         default: y = $urandom_range(1, 9999);
      endcase
      case ($urandom_range(5))
         0:       s = $urandom;
         1:       s = $urandom_range(LAST_SERIAL - 400, LAST_SERIAL + 2);
         2:       s = $urandom_range(3);
         default: s = $urandom_range(1, LAST_SERIAL);
      endcase
      case ($urandom_range(4))
         0:       off = $urandom;
         1:       off = $urandom_range(800) - 400;
         default: off = int'($urandom_range(2 * LAST_SERIAL)) - LAST_SERIAL;
      endcase
      offer(fn, ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(1, 28),
            $urandom_range(5) == 0 ? $urandom_range(15) : $urandom_range(1, 12), y, s, off);
   endtask

   // Response back-pressure, with one long hold-off to fill the pipeline.
   initial begin
      int cyc;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      for (cyc = 0; ; cyc++) begin
         @(posedge clock);
         if (cyc >= 300 && cyc < 400) rsp_ch.ready <= 1'b0;
         else if (calm) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(99) >= 33);
      end
   end

   initial begin
      int w;
      calm = 1'b0;
      sender_done = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.func <= FUNC_TO_SERIAL;
      req_ch.in_day <= '0;
      req_ch.in_month <= '0;
      req_ch.in_year <= '0;
      req_ch.in_serial <= '0;
      req_ch.offset <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      offer(FUNC_TO_SERIAL, 1, 1, 1, 0, 0);
      offer(FUNC_TO_SERIAL, 31, 12, 9999, 0, 0);
      offer(FUNC_TO_SERIAL, 1, 1, 10000, 0, 0);
      offer(FUNC_TO_SERIAL, 0, 0, 0, 0, 0);
      offer(FUNC_TO_SERIAL, 31, 15, 16383, 0, 0);
      offer(FUNC_TO_SERIAL, 29, 2, 2000, 0, 0);
      offer(FUNC_TO_SERIAL, 31, 2, 1900, 0, 0);
      offer(FUNC_TO_DATE, 0, 0, 0, 0, 0);
      offer(FUNC_TO_DATE, 0, 0, 0, 1, 0);
      offer(FUNC_TO_DATE, 0, 0, 0, LAST_SERIAL, 0);
      offer(FUNC_TO_DATE, 0, 0, 0, LAST_SERIAL + 1, 0);
      offer(FUNC_TO_DATE, 0, 0, 0, 4194303, 0);
      offer(FUNC_TO_DATE, 0, 0, 0, 146097, 0);
      offer(FUNC_TO_DATE, 0, 0, 0, 1461, 0);
      offer(FUNC_ADD, 1, 1, 1, 0, -1);
      offer(FUNC_ADD, 1, 3, 2000, 0, -1);
      offer(FUNC_ADD, 31, 12, 9999, 0, 1);
      offer(FUNC_ADD, 1, 1, 1, 0, 4194303);
      offer(FUNC_ADD, 31, 12, 9999, 0, -4194304);
      offer(FUNC_ADD, 31, 12, 9999, 0, 1 - LAST_SERIAL);
      offer(FUNC_DIFF, 1, 1, 1, LAST_SERIAL, 0);
      offer(FUNC_DIFF, 31, 12, 9999, 1, 0);
      offer(FUNC_DIFF, 1, 1, 1, 0, 0);
      offer(FUNC_DIFF, 1, 1, 10000, 5, 0);
      for (w = 0; w < 900; w++) begin
         calm = (w >= 500 && w < 650);
         random_date_item();
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;
      sender_done = 1'b1;
   end

   initial begin
      wait (sender_done);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
